@@ design/lmsw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_pkg
// Shared types and constants for the LED matrix shadow chain writer.
// ----------------------------------------------------------------------------
package lmsw_pkg;

    localparam int DEV_W  = 3;
    localparam int LINE_W = 3;
    localparam int BIT_W  = 3;
    localparam int BYTE_W = 8;
    localparam int CODE_W = 4;
    localparam int CMD_W  = 2;

    localparam int LINES_PER_DEV = 8;

    localparam int                MAX_DEVICES_DEF = 8;
    localparam logic [CODE_W-1:0] NOOP_CODE_DEF   = 4'd0;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [BYTE_W-1:0] MSB_MASK = 8'h80;

    typedef enum logic [CMD_W-1:0] {
        CMD_SET_PIXEL   = 2'd0,
        CMD_WRITE_LINE  = 2'd1,
        CMD_BIT_ACROSS  = 2'd2,
        CMD_CLEAR_DEV   = 2'd3
    } cmd_t;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [DEV_W-1:0]  device_index;
        logic [LINE_W-1:0] line_index;
        logic [BIT_W-1:0]  bit_index;
        logic              pixel_on;
        logic [BYTE_W-1:0] byte_value;
    } in_item_t;

    typedef struct packed {
        logic [CODE_W-1:0] register_code;
        logic [BYTE_W-1:0] frame_data;
        logic              transfer_end;
        logic              last_result;
    } out_item_t;

    // one chain transfer, as handed from front to back
    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [LINE_W-1:0] line;
        logic [BYTE_W-1:0] data;
        logic              last_cmd;
    } xfer_t;

endpackage

@@ design/led_matrix_shadow_chain_writer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_shadow_chain_writer
// Shadow-buffer writer for a chain of cascaded 8x8 LED matrices.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue-style port: a request is taken when push
//   is high and full is low. Frames leave the same way: the oldest frame sits
//   on result while empty is low and is taken when pop is high.
//   cfg_write/cfg_data set the index of the last device in the chain; write
//   it only while no command is in flight.
//   A command becomes one chain transfer (set pixel, write line) or eight
//   (bit across lines, clear device); each transfer is last_device+1 frames.
//   The front handles each line on the shadow RAM port in a read state,
//   then a modify-and-write state; the back emits one frame per cycle
//   unless the queue is empty or the receiver holds off pop. The first
//   frame of a command passes the read and modify states, the transfer
//   queue and the output register before it reaches result.
//   Reset clears the shadow buffer at once (per-line valid bits), empties
//   the queue and sets last_device to 0. When the receiver holds off pop,
//   the frame register and the transfer queue fill, then full stays high.
// ----------------------------------------------------------------------------
module led_matrix_shadow_chain_writer #(
    parameter int                            MAX_DEVICES = lmsw_pkg::MAX_DEVICES_DEF,
    parameter logic [lmsw_pkg::CODE_W-1:0]   NOOP_CODE   = lmsw_pkg::NOOP_CODE_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    output logic                       full,
    input  lmsw_pkg::in_item_t         item,
    input  logic                       cfg_write,
    input  logic [lmsw_pkg::DEV_W-1:0] cfg_data,
    output logic                       empty,
    input  logic                       pop,
    output lmsw_pkg::out_item_t        result
);
    import lmsw_pkg::*;

    logic [DEV_W-1:0] last_device_reg;
    logic [DEV_W-1:0] chain_last;
    logic             q_push, q_pop, q_full, q_empty;
    xfer_t            q_wdata, q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_device_reg <= '0;
        end
        else if (cfg_write)
        begin
            last_device_reg <= cfg_data;
        end
    end

    // clamp an over-long chain to the devices that exist
    assign chain_last = (32'(last_device_reg) > MAX_DEVICES - 1)
                      ? DEV_W'(MAX_DEVICES - 1) : last_device_reg;

    lmsw_front #(
        .MAX_DEVICES (MAX_DEVICES)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .q_push (q_push),
        .q_full (q_full),
        .q_data (q_wdata)
    );

    lmsw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (q_push),
        .wdata   (q_wdata),
        .q_full  (q_full),
        .rd      (q_pop),
        .q_empty (q_empty),
        .rdata   (q_head)
    );

    lmsw_back #(
        .NOOP_CODE (NOOP_CODE)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .chain_last (chain_last),
        .q_empty    (q_empty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .result     (result)
    );

endmodule

@@ design/lmsw_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ design/lmsw_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_front
// Accepts commands, updates the shadow buffer line by line and queues one
// chain transfer per touched line.
// ----------------------------------------------------------------------------
module lmsw_front #(
    parameter int MAX_DEVICES = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  lmsw_pkg::in_item_t item,
    output logic              q_push,
    input  logic              q_full,
    output lmsw_pkg::xfer_t   q_data
);
    import lmsw_pkg::*;

    localparam int DEPTH  = MAX_DEVICES * LINES_PER_DEV;
    localparam int ADDR_W = $clog2(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_MOD  = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [CMD_W-1:0]  cmd_reg;
    logic [DEV_W-1:0]  dev_reg;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [BIT_W-1:0]  bit_reg;
    logic              on_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [DEPTH-1:0]  valid_reg, valid_next;

    logic              accept;
    logic              multi;
    logic              dev_ok;
    logic              last_line;
    logic [ADDR_W-1:0] addr;
    logic              ram_we;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W-1:0] new_byte;
    logic [BYTE_W-1:0] mask;
    logic              bit_val;

    assign accept    = push && !full;
    assign full      = (state_reg != S_IDLE);
    assign multi     = cmd_reg[1];
    assign dev_ok    = (32'(dev_reg) < MAX_DEVICES);
    assign last_line = !multi || (line_reg == LINE_W'(LINES_PER_DEV - 1));
    assign addr      = ADDR_W'({dev_reg, line_reg});
    assign mask      = MSB_MASK >> bit_reg;
    assign bit_val   = (cmd_reg == CMD_SET_PIXEL) ? on_reg : byte_reg[line_reg];
    // never-written lines read as zero
    assign old_byte  = valid_reg[addr] ? ram_rdata : '0;

    always_comb
    begin
        unique case (cmd_t'(cmd_reg))
            CMD_SET_PIXEL,
            CMD_BIT_ACROSS: new_byte = bit_val ? (old_byte | mask) : (old_byte & ~mask);
            CMD_WRITE_LINE: new_byte = byte_reg;
            CMD_CLEAR_DEV:  new_byte = '0;
            default:        new_byte = '0;
        endcase
    end

    assign ram_re = (state_reg == S_READ);
    assign q_push = (state_reg == S_MOD) && !q_full;
    assign ram_we = q_push && dev_ok;

    assign q_data.device   = dev_reg;
    assign q_data.line     = line_reg;
    assign q_data.data     = new_byte;
    assign q_data.last_cmd = last_line;

    always_comb
    begin
        state_next = state_reg;
        line_next  = line_reg;
        valid_next = valid_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_READ;
                    line_next  = item.command[1] ? '0 : item.line_index;
                end
            end
            S_READ:
            begin
                state_next = S_MOD;
            end
            S_MOD:
            begin
                if (q_push)
                begin
                    if (ram_we)
                    begin
                        valid_next[addr] = 1'b1;
                    end
                    if (last_line)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                        line_next  = line_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        line_reg <= line_next;
        if (accept)
        begin
            cmd_reg  <= item.command;
            dev_reg  <= item.device_index;
            bit_reg  <= item.bit_index;
            on_reg   <= item.pixel_on;
            byte_reg <= item.byte_value;
        end
    end

    lmsw_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_shadow (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (new_byte),
        .re    (ram_re),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("front pushed into a full queue");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (full && state_reg == S_READ))
        else $error("front did not start a line read after a request");

endmodule

@@ design/lmsw_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_queue
// Short transfer queue between the front and the back.
// ----------------------------------------------------------------------------
module lmsw_queue #(
    parameter int DEPTH = 2
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr,
    input  lmsw_pkg::xfer_t wdata,
    output logic            q_full,
    input  logic            rd,
    output logic            q_empty,
    output lmsw_pkg::xfer_t rdata
);
    import lmsw_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    xfer_t             slot_reg [DEPTH];
    logic [PTR_W-1:0]  wptr_reg, rptr_reg;
    logic [CNT_W-1:0]  count_reg;

    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_empty = (count_reg == '0);
    assign rdata   = slot_reg[rptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (wr)
            begin
                wptr_reg <= (wptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wptr_reg + 1'b1;
            end
            if (rd)
            begin
                rptr_reg <= (rptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rptr_reg + 1'b1;
            end
            if (wr && !rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (rd && !wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slot_reg[wptr_reg] <= wdata;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

@@ design/lmsw_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmsw_back
// Expands each queued transfer into one frame per chained device and holds
// the oldest frame in an output register.
// ----------------------------------------------------------------------------
module lmsw_back #(
    parameter logic [lmsw_pkg::CODE_W-1:0] NOOP_CODE = 4'd0
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [lmsw_pkg::DEV_W-1:0] chain_last,
    input  logic                       q_empty,
    input  lmsw_pkg::xfer_t            q_head,
    output logic                       q_pop,
    input  logic                       pop,
    output logic                       empty,
    output lmsw_pkg::out_item_t        result
);
    import lmsw_pkg::*;

    logic [DEV_W-1:0] m_reg, m_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_reg, frame;
    logic             advance;
    logic             is_target;
    logic             is_last;

    assign advance   = !q_empty && (!out_valid_reg || pop);
    assign is_target = (m_reg == q_head.device);
    assign is_last   = (m_reg == chain_last);
    assign q_pop     = advance && is_last;

    assign frame.register_code = is_target ? ({1'b0, q_head.line} + CODE_W'(1)) : NOOP_CODE;
    assign frame.frame_data    = is_target ? q_head.data : '0;
    assign frame.transfer_end  = is_last;
    assign frame.last_result   = is_last && q_head.last_cmd;

    always_comb
    begin
        m_next         = m_reg;
        out_valid_next = out_valid_reg && !pop;
        if (advance)
        begin
            out_valid_next = 1'b1;
            m_next         = is_last ? '0 : m_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            m_reg         <= m_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_reg <= frame;
        end
    end

    assign empty  = !out_valid_reg;
    assign result = out_reg;

    a_last_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.last_result) |-> result.transfer_end)
        else $error("command end not on a transfer end");

    a_counter_in_chain: assert property (@(posedge clk) disable iff (!rst_n)
        m_reg <= chain_last || q_empty)
        else $error("device counter ran past the chain end");

endmodule

@@ dv/led_matrix_shadow_chain_writer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_shadow_chain_writer_tb
// Self-checking testbench for the LED matrix shadow chain writer. Drives
// pixel, line, bit-across and clear requests over every chain length and
// compares each frame against an in-bench shadow buffer and chain model.
// Sender and receiver throttle at random in several phases.
// ----------------------------------------------------------------------------
module led_matrix_shadow_chain_writer_tb;

    import lmsw_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RAND_PHASES   = 8;
    localparam int PHASE_ITEMS   = 56;

    logic                clk       = 1'b0;
    logic                rst_n;
    logic                push;
    logic                full;
    in_item_t            item;
    logic                cfg_write;
    logic [DEV_W-1:0]    cfg_data;
    logic                empty;
    logic                pop       = 1'b0;
    out_item_t           result;

    // shadow buffer as the chain should hold it, indexed {device, line}
    logic [BYTE_W-1:0]   shadow_bytes [0:63];
    logic [DEV_W-1:0]    chain_last;
    out_item_t           expected_frames [$];
    out_item_t           frame_want;

    int                  idle_pct;
    int                  stall_pct;
    int                  error_count;
    int                  frames_checked;
    int                  requests_sent;
    longint              cycle_count;

    led_matrix_shadow_chain_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $error("timeout after %0d cycles, %0d frames outstanding",
                   cycle_count, expected_frames.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    task automatic add_transfer(input logic [DEV_W-1:0] dev, input logic [LINE_W-1:0] line,
                                input logic [BYTE_W-1:0] data, input logic final_frame);
        out_item_t f;
        for (int m = 0; m <= int'(chain_last); m++)
        begin
            if (m == int'(dev))
            begin
                f.register_code = {1'b0, line} + 4'd1;
                f.frame_data    = data;
            end
            else
            begin
                f.register_code = NOOP_CODE_DEF;
                f.frame_data    = '0;
            end
            f.transfer_end = (m == int'(chain_last));
            f.last_result  = final_frame && (m == int'(chain_last));
            expected_frames.push_back(f);
        end
    endtask

    task automatic predict_frames(input in_item_t c);
        logic [BYTE_W-1:0] mask;
        logic [5:0]        idx;
        mask = MSB_MASK >> c.bit_index;
        case (cmd_t'(c.command))
            CMD_SET_PIXEL:
            begin
                idx = {c.device_index, c.line_index};
                shadow_bytes[idx] = c.pixel_on ? (shadow_bytes[idx] | mask)
                                               : (shadow_bytes[idx] & ~mask);
                add_transfer(c.device_index, c.line_index, shadow_bytes[idx], 1'b1);
            end
            CMD_WRITE_LINE:
            begin
                idx = {c.device_index, c.line_index};
                shadow_bytes[idx] = c.byte_value;
                add_transfer(c.device_index, c.line_index, c.byte_value, 1'b1);
            end
            CMD_BIT_ACROSS:
            begin
                for (int k = 0; k < LINES_PER_DEV; k++)
                begin
                    idx = {c.device_index, 3'(k)};
                    shadow_bytes[idx] = c.byte_value[k] ? (shadow_bytes[idx] | mask)
                                                        : (shadow_bytes[idx] & ~mask);
                    add_transfer(c.device_index, 3'(k), shadow_bytes[idx], k == 7);
                end
            end
            default:
            begin
                for (int k = 0; k < LINES_PER_DEV; k++)
                begin
                    shadow_bytes[{c.device_index, 3'(k)}] = '0;
                    add_transfer(c.device_index, 3'(k), '0, k == 7);
                end
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Result side: throttle pop and check every accepted frame
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("unexpected frame: register_code %0d frame_data 0x%02h",
                       result.register_code, result.frame_data);
                error_count++;
            end
            else
            begin
                frame_want = expected_frames.pop_front();
                if (result.register_code !== frame_want.register_code)
                begin
                    $error("register_code: expected %0d, got %0d",
                           frame_want.register_code, result.register_code);
                    error_count++;
                end
                if (result.frame_data !== frame_want.frame_data)
                begin
                    $error("frame_data: expected 0x%02h, got 0x%02h",
                           frame_want.frame_data, result.frame_data);
                    error_count++;
                end
                if (result.transfer_end !== frame_want.transfer_end)
                begin
                    $error("transfer_end: expected %0b, got %0b",
                           frame_want.transfer_end, result.transfer_end);
                    error_count++;
                end
                if (result.last_result !== frame_want.last_result)
                begin
                    $error("last_result: expected %0b, got %0b",
                           frame_want.last_result, result.last_result);
                    error_count++;
                end
                frames_checked++;
            end
        end
        pop <= ($urandom_range(0, 99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic in_item_t make_cmd(cmd_t cmd, int dev, int line, int bitpos,
                                          bit on, int val);
        in_item_t c;
        c.command      = cmd;
        c.device_index = DEV_W'(dev);
        c.line_index   = LINE_W'(line);
        c.bit_index    = BIT_W'(bitpos);
        c.pixel_on     = on;
        c.byte_value   = BYTE_W'(val);
        return c;
    endfunction

    // Leaves push high on return; the next call or a drain decides its fate.
    task automatic send_cmd(input in_item_t c);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        item <= c;
        do
            @(posedge clk);
        while (full);
        predict_frames(c);
        requests_sent++;
    endtask

    task automatic wait_quiet();
        push <= 1'b0;
        while (expected_frames.size() != 0)
            @(posedge clk);
        // hold off a little so the back end has really gone idle
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_chain(input int last_dev);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_data  <= DEV_W'(last_dev);
        @(posedge clk);
        cfg_write  <= 1'b0;
        chain_last  = DEV_W'(last_dev);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_pixel_and_line();
        set_chain(7);
        send_cmd(make_cmd(CMD_SET_PIXEL, 0, 0, 0, 1'b1, 8'h00));
        send_cmd(make_cmd(CMD_SET_PIXEL, 7, 7, 7, 1'b1, 8'hFF));
        send_cmd(make_cmd(CMD_SET_PIXEL, 7, 7, 7, 1'b0, 8'hFF));
        send_cmd(make_cmd(CMD_WRITE_LINE, 3, 5, 0, 1'b0, 8'hFF));
        send_cmd(make_cmd(CMD_WRITE_LINE, 3, 5, 7, 1'b1, 8'h00));
        send_cmd(make_cmd(CMD_WRITE_LINE, 4, 2, 3, 1'b0, 8'hA5));
    endtask

    task automatic test_bit_across_and_clear();
        send_cmd(make_cmd(CMD_BIT_ACROSS, 2, 0, 3, 1'b0, 8'hA5));
        send_cmd(make_cmd(CMD_BIT_ACROSS, 2, 7, 0, 1'b1, 8'hFF));
        send_cmd(make_cmd(CMD_BIT_ACROSS, 2, 0, 7, 1'b0, 8'h00));
        send_cmd(make_cmd(CMD_CLEAR_DEV, 2, 0, 0, 1'b0, 8'h00));
        send_cmd(make_cmd(CMD_CLEAR_DEV, 7, 7, 7, 1'b1, 8'hFF));
    endtask

    // device past the end of the chain: buffer updates, frames are all no-op
    task automatic test_off_chain_target();
        set_chain(2);
        send_cmd(make_cmd(CMD_WRITE_LINE, 6, 1, 0, 1'b0, 8'h5A));
        send_cmd(make_cmd(CMD_SET_PIXEL, 5, 0, 4, 1'b1, 8'h00));
        send_cmd(make_cmd(CMD_BIT_ACROSS, 3, 0, 2, 1'b1, 8'h3C));
        set_chain(7);
        send_cmd(make_cmd(CMD_SET_PIXEL, 6, 1, 0, 1'b1, 8'h00));
    endtask

    task automatic test_single_device();
        set_chain(0);
        send_cmd(make_cmd(CMD_SET_PIXEL, 0, 3, 2, 1'b1, 8'h00));
        send_cmd(make_cmd(CMD_CLEAR_DEV, 0, 0, 0, 1'b0, 8'h00));
        send_cmd(make_cmd(CMD_WRITE_LINE, 1, 4, 0, 1'b0, 8'h81));
    endtask

    // each request waits until the previous one has fully drained
    task automatic test_drain_between();
        set_chain(4);
        for (int n = 0; n < 5; n++)
        begin
            send_cmd(make_cmd(cmd_t'(n % 4), n, 7 - n, n + 2, n[0], 8'h5A ^ (n * 37)));
            wait_quiet();
        end
    endtask

    task automatic test_random_traffic();
        int        chain_order [RAND_PHASES] = '{7, 0, 3, 5, 1, 6, 2, 4};
        int        idle_prof   [4]           = '{0, 83, 0, 38};
        int        stall_prof  [4]           = '{0, 0, 83, 38};
        in_item_t  c;
        for (int p = 0; p < RAND_PHASES; p++)
        begin
            set_chain(chain_order[p]);
            idle_pct  = idle_prof[p % 4];
            stall_pct = stall_prof[p % 4];
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                c.command = CMD_W'($urandom_range(0, 3));
                // mostly aim inside the chain, sometimes past its end
                if ($urandom_range(0, 99) < 80)
                    c.device_index = DEV_W'($urandom_range(0, chain_order[p]));
                else
                    c.device_index = DEV_W'($urandom_range(0, 7));
                c.line_index = LINE_W'($urandom_range(0, 7));
                c.bit_index  = BIT_W'($urandom_range(0, 7));
                c.pixel_on   = 1'($urandom_range(0, 1));
                c.byte_value = BYTE_W'($urandom_range(0, 255));
                send_cmd(c);
            end
        end
        idle_pct  = 0;
        stall_pct = 0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        push           = 1'b0;
        item           = '0;
        cfg_write      = 1'b0;
        cfg_data       = '0;
        chain_last     = '0;
        idle_pct       = 0;
        stall_pct      = 0;
        error_count    = 0;
        frames_checked = 0;
        requests_sent  = 0;
        cycle_count    = 0;
        for (int i = 0; i < 64; i++)
            shadow_bytes[i] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_pixel_and_line();
        test_bit_across_and_clear();
        test_off_chain_target();
        test_single_device();
        test_drain_between();
        test_random_traffic();

        wait_quiet();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d requests over chain lengths 1 to 8, checked %0d frames",
                 requests_sent, frames_checked);
        $display("Covered all four commands, off-chain targets and throttled handshakes");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
